/* src/mtrc_pkg.sv */
`timescale 1ns / 1ps
// Package for the Modbus TCP to RTU converter: item types, frame constants
// and the byte-wide Modbus CRC16 update. No dependencies.
package mtrc_pkg;

   localparam int unsigned CountW = 17;
   localparam logic [CountW-1:0] CountMax = {CountW{1'b1}};

   // MBAP header byte positions
   localparam logic [CountW-1:0] PosTransHi = CountW'(0);
   localparam logic [CountW-1:0] PosTransLo = CountW'(1);
   localparam logic [CountW-1:0] PosProtoHi = CountW'(2);
   localparam logic [CountW-1:0] PosProtoLo = CountW'(3);
   localparam logic [CountW-1:0] PosLenHi   = CountW'(4);
   localparam logic [CountW-1:0] PosLenLo   = CountW'(5);
   localparam logic [CountW-1:0] HdrLen     = CountW'(6);
   localparam logic [CountW-1:0] MinFrame   = CountW'(8);
   localparam logic [15:0]       MinLen     = 16'd2;

   localparam logic [15:0] CrcInit = 16'hFFFF;
   localparam logic [15:0] CrcPoly = 16'hA001;

   // result queue depth: one waiting result plus a full burst of three
   localparam int unsigned QueueDepth = 4;
   localparam int unsigned QueueCntW  = 3;
   localparam int unsigned BurstMax   = 3;

   typedef struct packed {
      logic [7:0]  out_byte;
      logic        byte_valid;
      logic        out_last;
      logic        frame_ok;
      logic [15:0] trans_id;
   } rsp_item_type;

   // results produced by one accepted byte
   typedef struct packed {
      logic [1:0]                  count;
      rsp_item_type [BurstMax-1:0] items;
   } push_type;

   typedef struct packed {
      logic can_take;
   } queue_status_type;

   function automatic logic [15:0] crc_update(input logic [15:0] crc,
                                              input logic [7:0] b);
      logic [15:0] c;
      c = crc ^ {8'h00, b};
      for (int k = 0; k < 8; k++) begin
         if (c[0]) begin
            c = (c >> 1) ^ CrcPoly;
         end else begin
            c = c >> 1;
         end
      end
      return c;
   endfunction

endpackage

/* src/mtrc_if.sv */
`timescale 1ns / 1ps
// Valid/ready channel interfaces for the converter's byte input and result
// output. Depends on nothing.
interface mtrc_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] in_byte;
   logic       in_last;
   modport source (output valid, in_byte, in_last, input ready);
   modport sink   (input valid, in_byte, in_last, output ready);
endinterface

interface mtrc_rsp_if;
   logic        valid;
   logic        ready;
   logic [7:0]  out_byte;
   logic        byte_valid;
   logic        out_last;
   logic        frame_ok;
   logic [15:0] trans_id;
   modport source (output valid, out_byte, byte_valid, out_last, frame_ok, trans_id,
                   input ready);
   modport sink   (input valid, out_byte, byte_valid, out_last, frame_ok, trans_id,
                   output ready);
endinterface

/* src/mtrc_frame.sv */
`timescale 1ns / 1ps
// Frame tracker: MBAP header capture, byte counter, CRC16 and the results of
// each accepted byte. Depends on mtrc_pkg.
module mtrc_frame (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 accept,
   input  logic [7:0]           in_byte,
   input  logic                 in_last,
   output mtrc_pkg::push_type   push
);

   logic [mtrc_pkg::CountW-1:0] count_ff, count_in;
   logic [15:0] trans_ff, trans_in;
   logic [15:0] proto_ff, proto_in;
   logic [15:0] len_ff, len_in;
   logic [15:0] crc_ff, crc_in;

   logic [15:0] crc_base, crc_new;
   logic [15:0] trans_new, proto_new, len_new;
   logic [mtrc_pkg::CountW-1:0] count_new, size_need;
   logic        is_body, frame_ok;
   mtrc_pkg::rsp_item_type body_item, crc_lo_item, crc_hi_item, status_item;

   always_comb begin
      crc_base  = (count_ff == '0) ? mtrc_pkg::CrcInit : crc_ff;
      trans_new = trans_ff;
      proto_new = proto_ff;
      len_new   = len_ff;
      is_body   = 1'b0;
      case (count_ff)
         mtrc_pkg::PosTransHi: trans_new[15:8] = in_byte;
         mtrc_pkg::PosTransLo: trans_new[7:0]  = in_byte;
         mtrc_pkg::PosProtoHi: proto_new[15:8] = in_byte;
         mtrc_pkg::PosProtoLo: proto_new[7:0]  = in_byte;
         mtrc_pkg::PosLenHi:   len_new[15:8]   = in_byte;
         mtrc_pkg::PosLenLo:   len_new[7:0]    = in_byte;
         default:              is_body         = 1'b1;
      endcase
      crc_new   = is_body ? mtrc_pkg::crc_update(crc_base, in_byte) : crc_base;
      count_new = (count_ff != mtrc_pkg::CountMax) ? count_ff + 1'b1 : count_ff;
      size_need = {1'b0, len_new} + mtrc_pkg::HdrLen;
      frame_ok  = (count_new >= mtrc_pkg::MinFrame) && (proto_new == 16'h0000) &&
                  (len_new >= mtrc_pkg::MinLen) && (count_new == size_need);

      body_item   = '{out_byte: in_byte, byte_valid: 1'b1, out_last: 1'b0,
                      frame_ok: 1'b0, trans_id: 16'h0000};
      crc_lo_item = '{out_byte: crc_new[7:0], byte_valid: 1'b1, out_last: 1'b0,
                      frame_ok: 1'b0, trans_id: 16'h0000};
      crc_hi_item = '{out_byte: crc_new[15:8], byte_valid: 1'b1, out_last: 1'b1,
                      frame_ok: frame_ok, trans_id: trans_new};
      status_item = '{out_byte: 8'h00, byte_valid: 1'b0, out_last: 1'b1,
                      frame_ok: 1'b0, trans_id: trans_new};

      push.items = {crc_hi_item, crc_lo_item, body_item};
      push.count = 2'd0;
      if (accept) begin
         if (is_body) begin
            push.count = in_last ? 2'd3 : 2'd1;
         end else if (in_last) begin
            push.items[0] = status_item;
            push.count    = 2'd1;
         end
      end
   end

   always_comb begin
      count_in = count_ff;
      trans_in = trans_ff;
      proto_in = proto_ff;
      len_in   = len_ff;
      crc_in   = crc_ff;
      if (accept) begin
         if (in_last) begin
            count_in = '0;
            trans_in = 16'h0000;
            proto_in = 16'h0000;
            len_in   = 16'h0000;
            crc_in   = mtrc_pkg::CrcInit;
         end else begin
            count_in = count_new;
            trans_in = trans_new;
            proto_in = proto_new;
            len_in   = len_new;
            crc_in   = crc_new;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         trans_ff <= 16'h0000;
         proto_ff <= 16'h0000;
         len_ff   <= 16'h0000;
         crc_ff   <= mtrc_pkg::CrcInit;
      end else begin
         count_ff <= count_in;
         trans_ff <= trans_in;
         proto_ff <= proto_in;
         len_ff   <= len_in;
         crc_ff   <= crc_in;
      end
   end

   // a last byte always closes the frame and restarts the count
   a_last_clears: assert property (@(posedge clock) disable iff (reset)
      accept && in_last |=> count_ff == '0 && crc_ff == mtrc_pkg::CrcInit)
      else $error("frame state not cleared after last byte");

   // header bytes never produce a result unless they end the frame
   a_header_silent: assert property (@(posedge clock) disable iff (reset)
      accept && !in_last && count_ff < mtrc_pkg::HdrLen |-> push.count == 2'd0)
      else $error("header byte produced a result");

endmodule

/* src/mtrc_outq.sv */
`timescale 1ns / 1ps
// Result queue: holds up to four results and presents the oldest on the
// result channel. Depends on mtrc_pkg and mtrc_if.
module mtrc_outq (
   input  logic                          clock,
   input  logic                          reset,
   input  mtrc_pkg::push_type            push,
   output mtrc_pkg::queue_status_type    status,
   mtrc_rsp_if.source                    rsp
);

   mtrc_pkg::rsp_item_type slot_ff [mtrc_pkg::QueueDepth];
   mtrc_pkg::rsp_item_type slot_in [mtrc_pkg::QueueDepth];
   logic [mtrc_pkg::QueueCntW-1:0] cnt_ff, cnt_in;
   logic                           pop;
   logic [mtrc_pkg::QueueCntW-1:0] base;

   assign pop = (cnt_ff != '0) && rsp.ready;
   assign base = cnt_ff - {2'b00, pop};

   always_comb begin
      logic [mtrc_pkg::QueueCntW-1:0] src;
      logic [mtrc_pkg::QueueCntW-1:0] off;
      for (int i = 0; i < mtrc_pkg::QueueDepth; i++) begin
         src = mtrc_pkg::QueueCntW'(i) + {2'b00, pop};
         off = mtrc_pkg::QueueCntW'(i) - base;
         slot_in[i] = slot_ff[i];
         if (src < cnt_ff) begin
            slot_in[i] = slot_ff[src[1:0]];
         end else if (mtrc_pkg::QueueCntW'(i) >= base && off < {1'b0, push.count}) begin
            slot_in[i] = push.items[off[1:0]];
         end
      end
      cnt_in = base + {1'b0, push.count};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      slot_ff <= slot_in;
   end

   // room for a full burst whenever at most one result is waiting
   assign status.can_take = (cnt_ff <= mtrc_pkg::QueueCntW'(1));

   assign rsp.valid      = (cnt_ff != '0);
   assign rsp.out_byte   = slot_ff[0].out_byte;
   assign rsp.byte_valid = slot_ff[0].byte_valid;
   assign rsp.out_last   = slot_ff[0].out_last;
   assign rsp.frame_ok   = slot_ff[0].frame_ok;
   assign rsp.trans_id   = slot_ff[0].trans_id;

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push.count != 2'd0 |-> cnt_ff <= mtrc_pkg::QueueCntW'(1))
      else $error("result burst pushed into a busy queue");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= mtrc_pkg::QueueCntW'(mtrc_pkg::QueueDepth))
      else $error("result queue count out of range");

endmodule

/* src/modbus_tcp_to_rtu_convert.sv */
`timescale 1ns / 1ps
// Results are registered into the result queue, which offers the oldest one first.
// Throughput: one byte per cycle while at most one result is queued; a last body
// byte yields three results; the input stalls until the four-entry queue holds one.
// Frame state is updated in the same cycle a byte is transferred.
// Reset (synchronous, active high): empty queue, zero count and header, CRC 0xFFFF.
module modbus_tcp_to_rtu_convert (
   input  logic       clock,
   input  logic       reset,
   mtrc_req_if.sink   req_ch,
   mtrc_rsp_if.source rsp_ch
);

   mtrc_pkg::push_type         push;
   mtrc_pkg::queue_status_type q_status;
   logic                       accept;

   // take a byte only while the queue can absorb a full end-of-frame burst
   assign req_ch.ready = q_status.can_take;
   assign accept       = req_ch.valid && req_ch.ready;

   // header capture, count and CRC; emits zero to three results per byte
   mtrc_frame u_frame (
      .clock   (clock),
      .reset   (reset),
      .accept  (accept),
      .in_byte (req_ch.in_byte),
      .in_last (req_ch.in_last),
      .push    (push)
   );

   // hold results and present them one transfer at a time
   mtrc_outq u_outq (
      .clock  (clock),
      .reset  (reset),
      .push   (push),
      .status (q_status),
      .rsp    (rsp_ch)
   );

endmodule

/* test/mtrc_rtu_checker.sv */
`timescale 1ns / 1ps
// Checker for the Modbus TCP to RTU converter: watches both channels, predicts
// the RTU result stream and compares it. Depends on mtrc_pkg and mtrc_if.
module mtrc_rtu_checker (
   input  logic clock,
   input  logic reset,
   mtrc_req_if  req_mon,
   mtrc_rsp_if  rsp_mon,
   output int   fail_total,
   output int   open_count
);

   // predicted frame state
   logic [mtrc_pkg::CountW-1:0] frame_pos;
   logic [15:0]                 mbap_tid;
   logic [15:0]                 mbap_proto;
   logic [15:0]                 mbap_len;
   logic [15:0]                 crc_run;

   mtrc_pkg::rsp_item_type rtu_expect[$];
   int                     fails;

   initial begin
      fails      = 0;
      fail_total = 0;
      open_count = 0;
   end

   // bitwise form of the reflected Modbus CRC16
   function automatic logic [15:0] crc16_step(input logic [15:0] crc,
                                              input logic [7:0] b);
      logic [15:0] c;
      logic        fb;
      c = crc;
      for (int i = 0; i < 8; i++) begin
         fb = c[0] ^ b[i];
         c  = c >> 1;
         if (fb) begin
            c = c ^ mtrc_pkg::CrcPoly;
         end
      end
      return c;
   endfunction

   function automatic mtrc_pkg::rsp_item_type rtu_item(input logic [7:0] b,
                                                       input logic bv,
                                                       input logic lst, input logic ok,
                                                       input logic [15:0] tid);
      mtrc_pkg::rsp_item_type r;
      r.out_byte   = b;
      r.byte_valid = bv;
      r.out_last   = lst;
      r.frame_ok   = ok;
      r.trans_id   = tid;
      return r;
   endfunction

   task automatic predict_rtu(input logic [7:0] b, input logic lst);
      logic [mtrc_pkg::CountW-1:0] idx;
      int                          total;
      logic                        ok;
      idx = frame_pos;
      if (idx == '0) begin
         crc_run = mtrc_pkg::CrcInit;
      end
      case (idx)
         mtrc_pkg::PosTransHi: mbap_tid[15:8]   = b;
         mtrc_pkg::PosTransLo: mbap_tid[7:0]    = b;
         mtrc_pkg::PosProtoHi: mbap_proto[15:8] = b;
         mtrc_pkg::PosProtoLo: mbap_proto[7:0]  = b;
         mtrc_pkg::PosLenHi:   mbap_len[15:8]   = b;
         mtrc_pkg::PosLenLo:   mbap_len[7:0]    = b;
         default: begin
            crc_run = crc16_step(crc_run, b);
            rtu_expect.insert(rtu_expect.size(),
                              rtu_item(b, 1'b1, 1'b0, 1'b0, 16'h0000));
         end
      endcase
      // count saturates instead of wrapping
      if (frame_pos != mtrc_pkg::CountMax) begin
         frame_pos = frame_pos + 1'b1;
      end
      if (lst) begin
         total = int'(frame_pos);
         ok = (total >= int'(mtrc_pkg::MinFrame)) && (mbap_proto == 16'h0000) &&
              (mbap_len >= mtrc_pkg::MinLen) &&
              (total == int'(mtrc_pkg::HdrLen) + int'(mbap_len));
         if (idx < mtrc_pkg::HdrLen) begin
            rtu_expect.insert(rtu_expect.size(),
                              rtu_item(8'h00, 1'b0, 1'b1, 1'b0, mbap_tid));
         end else begin
            rtu_expect.insert(rtu_expect.size(),
                              rtu_item(crc_run[7:0], 1'b1, 1'b0, 1'b0, 16'h0000));
            rtu_expect.insert(rtu_expect.size(),
                              rtu_item(crc_run[15:8], 1'b1, 1'b1, ok, mbap_tid));
         end
         frame_pos  = '0;
         mbap_tid   = '0;
         mbap_proto = '0;
         mbap_len   = '0;
         crc_run    = mtrc_pkg::CrcInit;
      end
   endtask

   task automatic flag(input string what, input logic [15:0] want, input logic [15:0] got);
      fails++;
      $display("%0t: %s mismatch, expected %h, actual %h", $time, what, want, got);
   endtask

   always @(posedge clock) begin
      mtrc_pkg::rsp_item_type got;
      mtrc_pkg::rsp_item_type want;
      if (reset) begin
         frame_pos  = '0;
         mbap_tid   = '0;
         mbap_proto = '0;
         mbap_len   = '0;
         crc_run    = mtrc_pkg::CrcInit;
         rtu_expect.delete();
      end else begin
         if (req_mon.valid && req_mon.ready) begin
            predict_rtu(req_mon.in_byte, req_mon.in_last);
         end
         if (rsp_mon.valid && rsp_mon.ready) begin
            got = rtu_item(rsp_mon.out_byte, rsp_mon.byte_valid, rsp_mon.out_last,
                           rsp_mon.frame_ok, rsp_mon.trans_id);
            if (rtu_expect.size() == 0) begin
               fails++;
               $display("%0t: unexpected result, expected none, actual %h", $time, got);
            end else begin
               want = rtu_expect.pop_front();
               if (got.out_byte !== want.out_byte) begin
                  flag("out_byte", 16'(want.out_byte), 16'(got.out_byte));
               end
               if (got.byte_valid !== want.byte_valid) begin
                  flag("byte_valid", 16'(want.byte_valid), 16'(got.byte_valid));
               end
               if (got.out_last !== want.out_last) begin
                  flag("out_last", 16'(want.out_last), 16'(got.out_last));
               end
               if (got.frame_ok !== want.frame_ok) begin
                  flag("frame_ok", 16'(want.frame_ok), 16'(got.frame_ok));
               end
               if (got.trans_id !== want.trans_id) begin
                  flag("trans_id", want.trans_id, got.trans_id);
               end
            end
         end
      end
      fail_total <= fails;
      open_count <= rtu_expect.size();
   end

endmodule

/* test/modbus_tcp_to_rtu_convert_test.sv */
`timescale 1ns / 1ps
// Testbench top for the Modbus TCP to RTU converter: drives TCP frames in
// bursts, stalls the result side, and reports the verdict. Depends on
// mtrc_pkg, mtrc_if, the converter and mtrc_rtu_checker.
module modbus_tcp_to_rtu_convert_test;

   localparam int RandomBytes = 305;
   localparam int CycleLimit  = 3000000;
   localparam int DrainCycles = 10;

   // receiver stall patterns
   typedef enum int {RxFree, RxCoin, RxSparse} rx_mode_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   int   cycle_count = 0;
   int   fail_total;
   int   open_count;
   int   burst_left = 0;

   logic [7:0] frame_q[$];

   mtrc_req_if req_ch ();
   mtrc_rsp_if rsp_ch ();

   modbus_tcp_to_rtu_convert uut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   mtrc_rtu_checker rtu_check (
      .clock      (clock),
      .reset      (reset),
      .req_mon    (req_ch),
      .rsp_mon    (rsp_ch),
      .fail_total (fail_total),
      .open_count (open_count)
   );

   always #6 clock = ~clock;

   // watchdog: end a hung run
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CycleLimit) begin
         $display("== FAIL ==");
         $finish;
      end
   end

   // Offer one byte and hold it until transferred. Called at a rising edge.
   // Bursts of random length are separated by random gaps; lower valid only
   // when the gap really spans cycles, so valid never drops and rises in one step.
   task automatic send_byte(input logic [7:0] b, input logic lst);
      int   gap;
      logic hit;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 7) == 0) ? $urandom_range(4, 15) : $urandom_range(0, 3);
         if (gap > 0) begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 20);
      end
      req_ch.valid   <= 1'b1;
      req_ch.in_byte <= b;
      req_ch.in_last <= lst;
      burst_left--;
      // sample ready mid-cycle: inputs change only at rising edges
      do begin
         @(negedge clock);
         hit = req_ch.ready;
         @(posedge clock);
      end while (!hit);
   endtask

   // append one byte to the frame under construction
   task automatic add_byte(input logic [7:0] b);
      frame_q.insert(frame_q.size(), b);
   endtask

   // send the queued frame, flag on its final byte, then empty the queue
   task automatic send_frame();
      for (int i = 0; i < frame_q.size(); i++) begin
         send_byte(frame_q[i], i == frame_q.size() - 1);
      end
      frame_q.delete();
   endtask

   task automatic push_mbap(input logic [15:0] tid, input logic [15:0] proto,
                            input logic [15:0] len);
      add_byte(tid[15:8]);
      add_byte(tid[7:0]);
      add_byte(proto[15:8]);
      add_byte(proto[7:0]);
      add_byte(len[15:8]);
      add_byte(len[7:0]);
   endtask

   task automatic push_body(input int n);
      for (int i = 0; i < n; i++) begin
         add_byte(8'($urandom_range(0, 255)));
      end
   endtask

   // Build one random frame: mostly well formed, the rest broken on purpose.
   task automatic build_random_frame();
      int          kind;
      int          body;
      int          delta;
      logic [15:0] len;
      kind = $urandom_range(0, 99);
      len  = 16'($urandom_range(2, 12));
      if (kind < 70) begin
         // well formed: body length matches the MBAP length
         push_mbap(16'($urandom_range(0, 65535)), 16'h0000, len);
         push_body(int'(len));
      end else if (kind < 78) begin
         // bad protocol id
         push_mbap(16'($urandom_range(0, 65535)), 16'($urandom_range(1, 65535)), len);
         push_body(int'(len));
      end else if (kind < 88) begin
         // size disagrees with the length field
         delta = $urandom_range(0, 1) ? $urandom_range(1, 2) : -$urandom_range(1, 2);
         body  = int'(len) + delta;
         push_mbap(16'($urandom_range(0, 65535)), 16'h0000, len);
         push_body(body);
      end else if (kind < 94) begin
         // frame ends inside the header
         push_body($urandom_range(1, 6));
      end else begin
         // odd length fields: tiny, or anything at all with a short body
         if ($urandom_range(0, 1)) begin
            len = 16'($urandom_range(0, 1));
            body = int'(len);
         end else begin
            len = 16'($urandom_range(0, 65535));
            body = $urandom_range(1, 8);
         end
         push_mbap(16'($urandom_range(0, 65535)), 16'h0000, len);
         push_body(body);
         if (frame_q.size() == int'(mtrc_pkg::HdrLen)) begin
            add_byte(8'($urandom_range(0, 255)));
         end
      end
   endtask

   // Receiver: segments of random length in random stall patterns, plus two
   // long hold-offs so the result queue fills and the input stalls.
   initial begin
      rx_mode_type mode;
      int          seg_len;
      int          rx_cycle;
      rsp_ch.ready <= 1'b0;
      rx_cycle = 0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         mode    = rx_mode_type'($urandom_range(0, 2));
         seg_len = $urandom_range(1, 40);
         repeat (seg_len) begin
            if ((rx_cycle >= 150 && rx_cycle < 350) ||
                (rx_cycle >= 5000 && rx_cycle < 5200)) begin
               rsp_ch.ready <= 1'b0;
            end else begin
               case (mode)
                  RxFree: begin
                     rsp_ch.ready <= 1'b1;
                  end
                  RxCoin: begin
                     rsp_ch.ready <= 1'($urandom_range(0, 1));
                  end
                  default: begin
                     rsp_ch.ready <= ($urandom_range(0, 3) == 0);
                  end
               endcase
            end
            rx_cycle++;
            @(posedge clock);
         end
      end
   end

   // Stimulus and verdict
   initial begin
      int sent_random;
      req_ch.valid   <= 1'b0;
      req_ch.in_byte <= 8'h00;
      req_ch.in_last <= 1'b0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // Directed: shortest valid frame with all-ones and all-zero bytes
      push_mbap(16'hFFFF, 16'h0000, mtrc_pkg::MinLen);
      add_byte(8'hFF);
      add_byte(8'h00);
      send_frame();
      // frame ends on its first byte: status only, low id byte read as zero
      add_byte(8'hAB);
      send_frame();
      // frame ends at the last header byte
      push_mbap(16'h1234, 16'h0001, 16'h0000);
      send_frame();
      // one body byte only: passed with CRC but too short
      push_mbap(16'h0001, 16'h0000, 16'h0001);
      add_byte(8'h5A);
      send_frame();

      // Random frames
      sent_random = 0;
      while (sent_random < RandomBytes) begin
         build_random_frame();
         sent_random += frame_q.size();
         send_frame();
      end

      // drain, then let any stray results show up
      req_ch.valid <= 1'b0;
      do begin
         @(negedge clock);
      end while (open_count != 0);
      repeat (DrainCycles) @(negedge clock);

      if (fail_total == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule

/* files.f */
src/mtrc_pkg.sv
src/mtrc_if.sv
src/mtrc_frame.sv
src/mtrc_outq.sv
src/modbus_tcp_to_rtu_convert.sv
test/mtrc_rtu_checker.sv
test/modbus_tcp_to_rtu_convert_test.sv
